### src/weighted_top_k_register_picker_unit_assert.svh
// Assertion macros used by the picker controller.
// Needs a clock and an active-high synchronous reset in the using scope.
`ifndef WEIGHTED_TOP_K_REGISTER_PICKER_UNIT_ASSERT_SVH
`define WEIGHTED_TOP_K_REGISTER_PICKER_UNIT_ASSERT_SVH

// same-cycle implication
`define WTKRP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("picker check failed (same cycle)");

// next-cycle implication
`define WTKRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("picker check failed (next cycle)");

`endif

### src/wtkrp_pkg.sv
// Shared constants, codes and command/status types of the register picker.
// No dependencies.
package wtkrp_pkg;

   localparam int GENERAL_SLOTS = 5;
   localparam int FLOAT_SLOTS   = 4;
   localparam int MAX_LOCALS    = 1024;

   localparam int VAR_ID_W   = $clog2(MAX_LOCALS);
   localparam int TYPE_W     = 3;
   localparam int WEIGHT_W   = 32;
   localparam int SLOTCFG_W  = 3;
   localparam int REG_W      = 4;
   localparam int MASK_W     = 5;
   localparam int TOTAL_W    = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   localparam int GEN_CNT_W = $clog2(GENERAL_SLOTS + 1);
   localparam int FLT_CNT_W = $clog2(FLOAT_SLOTS + 1);
   localparam int SUM_W     = $clog2(GENERAL_SLOTS + FLOAT_SLOTS + 1);

   localparam logic [SLOTCFG_W-1:0] GEN_SLOTS_RESET  = SLOTCFG_W'(5);
   localparam logic [SLOTCFG_W-1:0] FLT_SLOTS_RESET  = SLOTCFG_W'(4);
   localparam logic [WEIGHT_W-1:0]  MIN_WEIGHT_RESET = WEIGHT_W'(2);

   typedef enum logic [TYPE_W-1:0] {
      TC_INTEGER = 3'd0,
      TC_POINTER = 3'd1,
      TC_FLOAT   = 3'd2,
      TC_DOUBLE  = 3'd3,
      TC_OTHER   = 3'd4
   } type_class_type;

   typedef enum logic [1:0] {
      CSR_GEN_SLOTS  = 2'd0,
      CSR_FLT_SLOTS  = 2'd1,
      CSR_MIN_WEIGHT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic insert;
      logic tally;
      logic pop;
   } cmd_type;

   typedef struct packed {
      logic last_item;
   } status_type;

endpackage

### src/wtkrp_chan_if.sv
// Request and response channel interfaces of the register picker.
// Depends on wtkrp_pkg for field widths.
interface wtkrp_req_if import wtkrp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [VAR_ID_W-1:0] var_id;
   logic [TYPE_W-1:0]   type_class;
   logic                address_taken;
   logic                volatile_type;
   logic                is_vararg_area;
   logic [WEIGHT_W-1:0] use_weight;
   logic                is_last_local;

   modport source (output valid, var_id, type_class, address_taken, volatile_type,
                   is_vararg_area, use_weight, is_last_local, input ready);
   modport sink   (input valid, var_id, type_class, address_taken, volatile_type,
                   is_vararg_area, use_weight, is_last_local, output ready);
endinterface

interface wtkrp_rsp_if import wtkrp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                has_assignment;
   logic [VAR_ID_W-1:0] assigned_var_id;
   logic [REG_W-1:0]    assigned_reg;
   logic [MASK_W-1:0]   gp_reg_mask;
   logic [TOTAL_W-1:0]  total_promoted;
   logic                last_result;

   modport source (output valid, has_assignment, assigned_var_id, assigned_reg,
                   gp_reg_mask, total_promoted, last_result, input ready);
   modport sink   (input valid, has_assignment, assigned_var_id, assigned_reg,
                   gp_reg_mask, total_promoted, last_result, output ready);
endinterface

### src/wtkrp_ctrl.sv
// Controller of the register picker: accept, tally and drain sequencing.
// Depends on wtkrp_pkg and the assertion macro header.
`include "weighted_top_k_register_picker_unit_assert.svh"

module wtkrp_ctrl import wtkrp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_TALLY = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.insert = req_valid;
            if (req_valid && req_last) state_in = ST_TALLY;
         end
         ST_TALLY: begin
            cmd.tally = 1'b1;
            state_in  = ST_DRAIN;
         end
         ST_DRAIN: begin
            rsp_valid = 1'b1;
            cmd.pop   = rsp_ready;
            if (rsp_ready && status.last_item) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `WTKRP_ASSERT_IMPL(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   `WTKRP_ASSERT_NEXT(a_last_tally, clock, reset, req_valid && req_ready && req_last, state_ff == ST_TALLY)
   `WTKRP_ASSERT_NEXT(a_tally_drain, clock, reset, state_ff == ST_TALLY, rsp_valid)
   `WTKRP_ASSERT_NEXT(a_final_idle, clock, reset, rsp_valid && rsp_ready && status.last_item, req_ready)

endmodule

### src/wtkrp_dp.sv
// Datapath of the register picker: CSRs, sorted general/float lists, tally and drain.
// Depends on wtkrp_pkg.
module wtkrp_dp import wtkrp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [VAR_ID_W-1:0]   req_var_id,
   input  logic [TYPE_W-1:0]     req_type_class,
   input  logic                  req_address_taken,
   input  logic                  req_volatile_type,
   input  logic                  req_is_vararg_area,
   input  logic [WEIGHT_W-1:0]   req_use_weight,
   output logic                  rsp_has_assignment,
   output logic [VAR_ID_W-1:0]   rsp_assigned_var_id,
   output logic [REG_W-1:0]      rsp_assigned_reg,
   output logic [MASK_W-1:0]     rsp_gp_reg_mask,
   output logic [TOTAL_W-1:0]    rsp_total_promoted,
   output logic                  rsp_last_result,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // csr
   logic [SLOTCFG_W-1:0] gen_slots_ff, flt_slots_ff;
   logic [WEIGHT_W-1:0]  min_weight_ff;
   csr_index_type        csr_idx;
   logic                 csr_wr;

   assign pready  = 1'b1;
   assign csr_idx = csr_index_type'(paddr[3:2]);
   assign csr_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_slots_ff  <= GEN_SLOTS_RESET;
         flt_slots_ff  <= FLT_SLOTS_RESET;
         min_weight_ff <= MIN_WEIGHT_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_GEN_SLOTS:  gen_slots_ff  <= pwdata[SLOTCFG_W-1:0];
            CSR_FLT_SLOTS:  flt_slots_ff  <= pwdata[SLOTCFG_W-1:0];
            CSR_MIN_WEIGHT: min_weight_ff <= pwdata[WEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (csr_idx)
         CSR_GEN_SLOTS:  prdata = CSR_DATA_W'(gen_slots_ff);
         CSR_FLT_SLOTS:  prdata = CSR_DATA_W'(flt_slots_ff);
         CSR_MIN_WEIGHT: prdata = CSR_DATA_W'(min_weight_ff);
         default:        prdata = '0;
      endcase
   end

   // effective slot counts
   logic [GEN_CNT_W-1:0] ng;
   logic [FLT_CNT_W-1:0] nf;

   always_comb begin
      if (int'(gen_slots_ff) > GENERAL_SLOTS) ng = GEN_CNT_W'(GENERAL_SLOTS);
      else                                    ng = GEN_CNT_W'(gen_slots_ff);
      if (int'(flt_slots_ff) > FLOAT_SLOTS)   nf = FLT_CNT_W'(FLOAT_SLOTS);
      else                                    nf = FLT_CNT_W'(flt_slots_ff);
   end

   // candidate classification
   logic qualifies, gen_cand, flt_cand;

   assign qualifies = !(req_address_taken || req_volatile_type || req_is_vararg_area)
                      && (req_use_weight >= min_weight_ff);

   always_comb begin
      gen_cand = 1'b0;
      flt_cand = 1'b0;
      case (req_type_class) inside
         TC_INTEGER, TC_POINTER: gen_cand = qualifies;
         TC_FLOAT, TC_DOUBLE:    flt_cand = qualifies;
         default: ;
      endcase
   end

   // lists
   logic [GENERAL_SLOTS-1:0] gen_v_ff, gen_v_in;
   logic [WEIGHT_W-1:0]      gen_w_ff  [GENERAL_SLOTS];
   logic [WEIGHT_W-1:0]      gen_w_in  [GENERAL_SLOTS];
   logic [VAR_ID_W-1:0]      gen_id_ff [GENERAL_SLOTS];
   logic [VAR_ID_W-1:0]      gen_id_in [GENERAL_SLOTS];
   logic [GENERAL_SLOTS-1:0] gen_hit, gen_before, gen_nmask;

   logic [FLOAT_SLOTS-1:0]   flt_v_ff, flt_v_in;
   logic [WEIGHT_W-1:0]      flt_w_ff  [FLOAT_SLOTS];
   logic [WEIGHT_W-1:0]      flt_w_in  [FLOAT_SLOTS];
   logic [VAR_ID_W-1:0]      flt_id_ff [FLOAT_SLOTS];
   logic [VAR_ID_W-1:0]      flt_id_in [FLOAT_SLOTS];
   logic [FLOAT_SLOTS-1:0]   flt_hit, flt_before, flt_nmask;

   // drain bookkeeping
   logic [GEN_CNT_W-1:0] gp_ff, gp_now, g_idx_ff;
   logic [FLT_CNT_W-1:0] fc_ff, fc_now, f_idx_ff;
   logic [MASK_W-1:0]    mask_ff, mask_now;
   logic [TOTAL_W-1:0]   total_ff;
   logic                 g_sel, has_any, is_last;
   logic [SUM_W-1:0]     sum_all, sum_done, reg_no;

   always_comb begin
      logic run_g, run_f;
      run_g = 1'b0;
      run_f = 1'b0;
      for (int j = 0; j < GENERAL_SLOTS; j++) begin
         gen_nmask[j]  = (j < int'(ng));
         gen_hit[j]    = gen_nmask[j] && (!gen_v_ff[j] || req_use_weight > gen_w_ff[j]);
         gen_before[j] = run_g;
         run_g         = run_g | gen_hit[j];
      end
      for (int j = 0; j < FLOAT_SLOTS; j++) begin
         flt_nmask[j]  = (j < int'(nf));
         flt_hit[j]    = flt_nmask[j] && (!flt_v_ff[j] || req_use_weight > flt_w_ff[j]);
         flt_before[j] = run_f;
         run_f         = run_f | flt_hit[j];
      end
   end

   assign gp_now = GEN_CNT_W'($countones(gen_v_ff & gen_nmask));
   assign fc_now = FLT_CNT_W'($countones(flt_v_ff & flt_nmask));

   always_comb begin
      for (int i = 0; i < MASK_W; i++) mask_now[i] = (i < int'(gp_now));
   end

   assign g_sel    = (g_idx_ff < gp_ff);
   assign sum_all  = SUM_W'(gp_ff) + SUM_W'(fc_ff);
   assign sum_done = SUM_W'(g_idx_ff) + SUM_W'(f_idx_ff) + SUM_W'(1);
   assign has_any  = (sum_all != '0);
   assign is_last  = !has_any || (sum_done == sum_all);
   assign reg_no   = g_sel ? SUM_W'(g_idx_ff) : SUM_W'(GENERAL_SLOTS) + SUM_W'(f_idx_ff);

   always_comb begin
      gen_v_in  = gen_v_ff;
      gen_w_in  = gen_w_ff;
      gen_id_in = gen_id_ff;
      flt_v_in  = flt_v_ff;
      flt_w_in  = flt_w_ff;
      flt_id_in = flt_id_ff;
      if (cmd.insert && gen_cand) begin
         for (int j = 1; j < GENERAL_SLOTS; j++) begin
            if (gen_before[j] && gen_nmask[j]) begin
               gen_v_in[j]  = gen_v_ff[j-1];
               gen_w_in[j]  = gen_w_ff[j-1];
               gen_id_in[j] = gen_id_ff[j-1];
            end
         end
         for (int j = 0; j < GENERAL_SLOTS; j++) begin
            if (gen_hit[j] && !gen_before[j]) begin
               gen_v_in[j]  = 1'b1;
               gen_w_in[j]  = req_use_weight;
               gen_id_in[j] = req_var_id;
            end
         end
      end
      if (cmd.insert && flt_cand) begin
         for (int j = 1; j < FLOAT_SLOTS; j++) begin
            if (flt_before[j] && flt_nmask[j]) begin
               flt_v_in[j]  = flt_v_ff[j-1];
               flt_w_in[j]  = flt_w_ff[j-1];
               flt_id_in[j] = flt_id_ff[j-1];
            end
         end
         for (int j = 0; j < FLOAT_SLOTS; j++) begin
            if (flt_hit[j] && !flt_before[j]) begin
               flt_v_in[j]  = 1'b1;
               flt_w_in[j]  = req_use_weight;
               flt_id_in[j] = req_var_id;
            end
         end
      end
      if (cmd.pop) begin
         // heads shift out one per response
         if (g_sel) begin
            gen_v_in = gen_v_ff >> 1;
            for (int j = 0; j < GENERAL_SLOTS - 1; j++) begin
               gen_w_in[j]  = gen_w_ff[j+1];
               gen_id_in[j] = gen_id_ff[j+1];
            end
         end else begin
            flt_v_in = flt_v_ff >> 1;
            for (int j = 0; j < FLOAT_SLOTS - 1; j++) begin
               flt_w_in[j]  = flt_w_ff[j+1];
               flt_id_in[j] = flt_id_ff[j+1];
            end
         end
         if (is_last) begin
            gen_v_in = '0;
            flt_v_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      gen_w_ff  <= gen_w_in;
      gen_id_ff <= gen_id_in;
      flt_w_ff  <= flt_w_in;
      flt_id_ff <= flt_id_in;
      if (reset) begin
         gen_v_ff <= '0;
         flt_v_ff <= '0;
         gp_ff    <= '0;
         fc_ff    <= '0;
         g_idx_ff <= '0;
         f_idx_ff <= '0;
         mask_ff  <= '0;
         total_ff <= '0;
      end else begin
         gen_v_ff <= gen_v_in;
         flt_v_ff <= flt_v_in;
         if (cmd.tally) begin
            gp_ff    <= gp_now;
            fc_ff    <= fc_now;
            g_idx_ff <= '0;
            f_idx_ff <= '0;
            mask_ff  <= mask_now;
            total_ff <= total_ff + TOTAL_W'(gp_now) + TOTAL_W'(fc_now);
         end else if (cmd.pop && has_any) begin
            if (g_sel) g_idx_ff <= g_idx_ff + GEN_CNT_W'(1);
            else       f_idx_ff <= f_idx_ff + FLT_CNT_W'(1);
         end
      end
   end

   assign rsp_has_assignment  = has_any;
   assign rsp_assigned_var_id = !has_any ? '0 : (g_sel ? gen_id_ff[0] : flt_id_ff[0]);
   assign rsp_assigned_reg    = has_any ? REG_W'(reg_no) : '0;
   assign rsp_gp_reg_mask     = mask_ff;
   assign rsp_total_promoted  = total_ff;
   assign rsp_last_result     = is_last;
   assign status.last_item    = is_last;

endmodule

### src/weighted_top_k_register_picker_unit.sv
// Top level of the weighted top-k register picker: request/response channels and APB CSRs.
// Sequence: requests are accepted in the idle state; the last request of a function leads
// to the tally state, then one response per chosen variable (at least one), up to nine.
// Throughput: one request per cycle while idle (compare-and-shift list insert); the drain
// pops one head per cycle when rsp_ready is high; requests wait until the final response.
// Reset (synchronous): lists empty, total zero, CSRs 5 / 4 / 2; no clearing pass.
module weighted_top_k_register_picker_unit import wtkrp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   wtkrp_req_if.sink             req_ch,
   wtkrp_rsp_if.source           rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cmd_type    cmd;
   status_type status;

   wtkrp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_last  (req_ch.is_last_local),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   wtkrp_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_var_id          (req_ch.var_id),
      .req_type_class      (req_ch.type_class),
      .req_address_taken   (req_ch.address_taken),
      .req_volatile_type   (req_ch.volatile_type),
      .req_is_vararg_area  (req_ch.is_vararg_area),
      .req_use_weight      (req_ch.use_weight),
      .rsp_has_assignment  (rsp_ch.has_assignment),
      .rsp_assigned_var_id (rsp_ch.assigned_var_id),
      .rsp_assigned_reg    (rsp_ch.assigned_reg),
      .rsp_gp_reg_mask     (rsp_ch.gp_reg_mask),
      .rsp_total_promoted  (rsp_ch.total_promoted),
      .rsp_last_result     (rsp_ch.last_result),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

endmodule

### tb/tb_weighted_top_k_register_picker_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for weighted_top_k_register_picker_unit: random requests and
// APB CSR phases against an in-bench predictor of the top-k general and float lists.
// Depends on wtkrp_pkg and the wtkrp_req_if / wtkrp_rsp_if channel interfaces.
module tb_weighted_top_k_register_picker_unit;
   import wtkrp_pkg::*;

   localparam int GEN_LIST   = 0;
   localparam int FLT_LIST   = 1;
   localparam int LIST_DEPTH = (GENERAL_SLOTS > FLOAT_SLOTS) ? GENERAL_SLOTS : FLOAT_SLOTS;

   typedef struct packed {
      logic [VAR_ID_W-1:0] var_id;
      logic [TYPE_W-1:0]   type_class;
      logic                address_taken;
      logic                volatile_type;
      logic                is_vararg_area;
      logic [WEIGHT_W-1:0] use_weight;
      logic                is_last_local;
   } request_type;

   typedef struct packed {
      logic                has_assignment;
      logic [VAR_ID_W-1:0] var_id;
      logic [REG_W-1:0]    reg_no;
      logic [MASK_W-1:0]   mask;
      logic [TOTAL_W-1:0]  total;
      logic                last;
   } assignment_type;

   typedef struct {
      bit                live;
      bit [WEIGHT_W-1:0] weight;
      bit [VAR_ID_W-1:0] id;
   } candidate_type;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   wtkrp_req_if req_bus ();
   wtkrp_rsp_if rsp_bus ();

   weighted_top_k_register_picker_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_bus),
      .rsp_ch  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   candidate_type        ranked [2][LIST_DEPTH];
   logic [TOTAL_W-1:0]   promoted_total;
   logic [SLOTCFG_W-1:0] gen_slots_cfg;
   logic [SLOTCFG_W-1:0] flt_slots_cfg;
   logic [WEIGHT_W-1:0]  min_weight_cfg;
   assignment_type       pending_assignments [$];

   int error_count;
   int requests_sent;
   int stall_left;
   bit send_idle_on;
   bit rsp_stall_on;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic void rank_insert(int list, int n, logic [VAR_ID_W-1:0] id,
                                       logic [WEIGHT_W-1:0] w);
      int i;
      int j;
      for (i = 0; i < n; i++) begin
         if (!ranked[list][i].live || w > ranked[list][i].weight) begin
            for (j = n - 1; j > i; j--)
               ranked[list][j] = ranked[list][j-1];
            ranked[list][i].live   = 1'b1;
            ranked[list][i].weight = w;
            ranked[list][i].id     = id;
            return;
         end
      end
   endfunction

   function automatic int leading_live(int list, int n);
      int c;
      c = 0;
      while (c < n && ranked[list][c].live)
         c++;
      return c;
   endfunction

   // updates the lists for one accepted request and queues the assignments it releases
   function automatic void pick_registers(request_type r);
      int ng;
      int nf;
      int gp;
      int fc;
      int i;
      int k;
      logic [MASK_W-1:0] mask;
      assignment_type a;
      ng = (gen_slots_cfg > GENERAL_SLOTS) ? GENERAL_SLOTS : gen_slots_cfg;
      nf = (flt_slots_cfg > FLOAT_SLOTS) ? FLOAT_SLOTS : flt_slots_cfg;
      if (!(r.address_taken || r.volatile_type || r.is_vararg_area) &&
          r.use_weight >= min_weight_cfg) begin
         if (r.type_class == TC_INTEGER || r.type_class == TC_POINTER)
            rank_insert(GEN_LIST, ng, r.var_id, r.use_weight);
         else if (r.type_class == TC_FLOAT || r.type_class == TC_DOUBLE)
            rank_insert(FLT_LIST, nf, r.var_id, r.use_weight);
      end
      if (!r.is_last_local)
         return;
      gp = leading_live(GEN_LIST, ng);
      fc = leading_live(FLT_LIST, nf);
      promoted_total += TOTAL_W'(gp + fc);
      mask = '0;
      for (i = 0; i < gp; i++)
         mask[i] = 1'b1;
      if (gp + fc == 0) begin
         a = '{1'b0, '0, '0, '0, promoted_total, 1'b1};
         pending_assignments.push_back(a);
      end else begin
         k = 0;
         for (i = 0; i < gp; i++, k++) begin
            a = '{1'b1, ranked[GEN_LIST][i].id, REG_W'(i), mask, promoted_total,
                  k == gp + fc - 1};
            pending_assignments.push_back(a);
         end
         for (i = 0; i < fc; i++, k++) begin
            a = '{1'b1, ranked[FLT_LIST][i].id, REG_W'(GENERAL_SLOTS + i), mask,
                  promoted_total, k == gp + fc - 1};
            pending_assignments.push_back(a);
         end
      end
      foreach (ranked[l, s])
         ranked[l][s].live = 1'b0;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endfunction

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_bus.ready = 1'b0;
         stall_left--;
      end else if (rsp_stall_on && $urandom_range(0, 4) == 0) begin
         rsp_bus.ready = 1'b0;
         stall_left = $urandom_range(1, 16) - 1;
      end else begin
         rsp_bus.ready = 1'b1;
      end
   end

   always @(posedge clock) begin
      assignment_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_assignments.size() == 0) begin
            $error("response with no assignment pending: var_id 0x%0h",
                   rsp_bus.assigned_var_id);
            error_count++;
         end else begin
            want = pending_assignments.pop_front();
            check_field("has_assignment", want.has_assignment, rsp_bus.has_assignment);
            check_field("assigned_var_id", want.var_id, rsp_bus.assigned_var_id);
            check_field("assigned_reg", want.reg_no, rsp_bus.assigned_reg);
            check_field("gp_reg_mask", want.mask, rsp_bus.gp_reg_mask);
            check_field("total_promoted", want.total, rsp_bus.total_promoted);
            check_field("last_result", want.last, rsp_bus.last_result);
         end
      end
   end

   task automatic send_request(request_type r);
      req_bus.var_id         = r.var_id;
      req_bus.type_class     = r.type_class;
      req_bus.address_taken  = r.address_taken;
      req_bus.volatile_type  = r.volatile_type;
      req_bus.is_vararg_area = r.is_vararg_area;
      req_bus.use_weight     = r.use_weight;
      req_bus.is_last_local  = r.is_last_local;
      req_bus.valid          = 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      pick_registers(r);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic sender_pause();
      if (send_idle_on && $urandom_range(0, 4) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
   endtask

   task automatic wait_until_drained();
      req_bus.valid = 1'b0;
      while (pending_assignments.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic read_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] want);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = {idx, 2'b00};
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata !== want) begin
         $error("csr %s readback: expected 0x%0h, got 0x%0h", idx.name(), want, prdata);
         error_count++;
      end
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      case (idx)
         CSR_GEN_SLOTS:  gen_slots_cfg  = value[SLOTCFG_W-1:0];
         CSR_FLT_SLOTS:  flt_slots_cfg  = value[SLOTCFG_W-1:0];
         CSR_MIN_WEIGHT: min_weight_cfg = value;
         default: ;
      endcase
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      if (idx == CSR_MIN_WEIGHT)
         read_csr(idx, value);
      else
         read_csr(idx, CSR_DATA_W'(value[SLOTCFG_W-1:0]));
   endtask

   task automatic write_slot_config(logic [SLOTCFG_W-1:0] gen, logic [SLOTCFG_W-1:0] flt,
                                    logic [WEIGHT_W-1:0] min_w);
      write_csr(CSR_GEN_SLOTS, CSR_DATA_W'(gen));
      write_csr(CSR_FLT_SLOTS, CSR_DATA_W'(flt));
      write_csr(CSR_MIN_WEIGHT, min_w);
   endtask

   function automatic request_type make_request(int id, logic [TYPE_W-1:0] tc,
                                                logic [WEIGHT_W-1:0] w, bit last,
                                                bit at = 0, bit vol = 0, bit va = 0);
      request_type r;
      r.var_id         = VAR_ID_W'(id);
      r.type_class     = tc;
      r.address_taken  = at;
      r.volatile_type  = vol;
      r.is_vararg_area = va;
      r.use_weight     = w;
      r.is_last_local  = last;
      return r;
   endfunction

   function automatic request_type random_request(bit last);
      request_type r;
      int pick;
      r.var_id = VAR_ID_W'($urandom);
      pick = $urandom_range(0, 19);
      if (pick < 16)
         r.type_class = TYPE_W'(pick % 4);
      else if (pick < 19)
         r.type_class = TC_OTHER;
      else
         r.type_class = TYPE_W'($urandom_range(int'(TC_OTHER) + 1, (1 << TYPE_W) - 1));
      r.address_taken  = ($urandom_range(0, 9) == 0);
      r.volatile_type  = ($urandom_range(0, 9) == 0);
      r.is_vararg_area = ($urandom_range(0, 9) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 6)
         r.use_weight = $urandom_range(0, 24);
      else if (pick < 8)
         r.use_weight = $urandom;
      else if (pick == 8)
         r.use_weight = '1;
      else
         r.use_weight = min_weight_cfg;
      r.is_last_local = last;
      return r;
   endfunction

   task automatic send_function(int len);
      int k;
      for (k = 0; k < len; k++) begin
         sender_pause();
         send_request(random_request(k == len - 1));
      end
   endtask

   function automatic int random_length();
      return ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
   endfunction

   task automatic test_reset_values();
      read_csr(CSR_GEN_SLOTS, CSR_DATA_W'(GEN_SLOTS_RESET));
      read_csr(CSR_FLT_SLOTS, CSR_DATA_W'(FLT_SLOTS_RESET));
      read_csr(CSR_MIN_WEIGHT, MIN_WEIGHT_RESET);
   endtask

   task automatic test_directed();
      int k;
      // nothing qualifies: empty result
      send_request(make_request(1, TC_INTEGER, 1, 1));
      // field extremes, every type class, each reject flag, threshold and ties
      send_request(make_request(1023, TC_INTEGER, '1, 0));
      send_request(make_request(0, TC_POINTER, MIN_WEIGHT_RESET, 0));
      send_request(make_request(5, TC_FLOAT, 100, 0));
      send_request(make_request(6, TC_DOUBLE, 100, 0));
      send_request(make_request(7, TC_OTHER, 50, 0));
      send_request(make_request(8, '1, 50, 0));
      send_request(make_request(9, TC_INTEGER, 1000, 0, 1, 0, 0));
      send_request(make_request(10, TC_POINTER, 1000, 0, 0, 1, 0));
      send_request(make_request(11, TC_DOUBLE, 1000, 0, 0, 0, 1));
      send_request(make_request(12, TC_INTEGER, 0, 0));
      send_request(make_request(13, TC_INTEGER, 3, 1));
      // both lists overflow
      for (k = 0; k < 6; k++)
         send_request(make_request(100 + k, TC_INTEGER, 10 * (k + 1), 0));
      send_request(make_request(200, TC_FLOAT, 7, 0));
      send_request(make_request(201, TC_DOUBLE, 7, 0));
      send_request(make_request(202, TC_FLOAT, 9, 0));
      send_request(make_request(203, TC_DOUBLE, 9, 0));
      send_request(make_request(204, TC_FLOAT, 8, 1));
      wait_until_drained();
   endtask

   task automatic test_mid_function_change();
      int k;
      for (k = 0; k < 3; k++)
         send_request(make_request(300 + k, TC_INTEGER, 10 * (k + 1), 0));
      send_request(make_request(310, TC_FLOAT, 40, 0));
      wait_until_drained();
      write_csr(CSR_GEN_SLOTS, 1);
      write_csr(CSR_FLT_SLOTS, 0);
      send_request(make_request(320, TC_INTEGER, 5, 0));
      send_request(make_request(321, TC_FLOAT, 50, 1));
      wait_until_drained();
      write_csr(CSR_GEN_SLOTS, 2);
      for (k = 0; k < 3; k++)
         send_request(make_request(330 + k, TC_POINTER, 10 * (k + 1), 0));
      wait_until_drained();
      write_slot_config(GEN_SLOTS_RESET, FLT_SLOTS_RESET, MIN_WEIGHT_RESET);
      send_request(make_request(340, TC_INTEGER, 15, 1));
      wait_until_drained();
   endtask

   task automatic test_slot_settings();
      logic [SLOTCFG_W-1:0] gen_set [5] = '{3'd0, 3'd7, 3'd1, 3'd6, 3'd5};
      logic [SLOTCFG_W-1:0] flt_set [5] = '{3'd0, 3'd7, 3'd2, 3'd1, 3'd4};
      logic [WEIGHT_W-1:0]  min_set [5] = '{32'd0, 32'd0, 32'hFFFF_FFFF, 32'd5, 32'd2};
      int s;
      int f;
      for (s = 0; s < 5; s++) begin
         write_slot_config(gen_set[s], flt_set[s], min_set[s]);
         for (f = 0; f < 5; f++)
            send_function(random_length());
         wait_until_drained();
      end
   endtask

   task automatic test_random();
      int phase;
      int stop_at;
      for (phase = 0; phase < 4; phase++) begin
         if (phase < 3) begin
            write_slot_config(SLOTCFG_W'($urandom_range(0, 7)),
                              SLOTCFG_W'($urandom_range(0, 7)),
                              ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 12));
         end else begin
            write_slot_config(GEN_SLOTS_RESET, FLT_SLOTS_RESET, MIN_WEIGHT_RESET);
         end
         stop_at = requests_sent + 55;
         while (requests_sent < stop_at) begin
            send_idle_on = (phase < 3) && ($urandom_range(0, 3) != 0);
            rsp_stall_on = (phase < 3) && ($urandom_range(0, 3) != 0);
            send_function(random_length());
         end
         wait_until_drained();
      end
   endtask

   initial begin
      reset   = 1'b1;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      req_bus.valid          = 1'b0;
      req_bus.var_id         = '0;
      req_bus.type_class     = TC_INTEGER;
      req_bus.address_taken  = 1'b0;
      req_bus.volatile_type  = 1'b0;
      req_bus.is_vararg_area = 1'b0;
      req_bus.use_weight     = '0;
      req_bus.is_last_local  = 1'b0;
      rsp_bus.ready          = 1'b0;
      error_count    = 0;
      requests_sent  = 0;
      stall_left     = 0;
      send_idle_on   = 1'b1;
      rsp_stall_on   = 1'b1;
      promoted_total = '0;
      gen_slots_cfg  = GEN_SLOTS_RESET;
      flt_slots_cfg  = FLT_SLOTS_RESET;
      min_weight_cfg = MIN_WEIGHT_RESET;
      foreach (ranked[l, s])
         ranked[l][s] = '{1'b0, '0, '0};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_values();
      test_directed();
      test_mid_function_change();
      test_slot_settings();
      test_random();

      wait_until_drained();
      repeat (12) @(negedge clock);
      if (error_count == 0 && pending_assignments.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
